// File: sv/nda_pkg.sv
// ----------------------------------------------------------------------------
// nda_pkg: shared constants and helpers for the nucleotide diversity block
// Field widths, the sample-size limit and the effective-n function.
// ----------------------------------------------------------------------------
package nda_pkg;

  localparam int unsigned CountW   = 9;   // sample_size and derived_count
  localparam int unsigned LenW     = 32;  // locus_length
  localparam int unsigned CfgDataW = 32;  // widest configuration register
  localparam int unsigned SumW     = 40;  // heterozygosity sum
  localparam int unsigned NsqW     = 17;  // n*n for n up to MaxSamples
  localparam int unsigned DenW     = NsqW + LenW;  // n*n*L
  localparam int unsigned ThetaW   = 32;  // Q8.24 result
  localparam int unsigned LoBits   = 7;   // sum bits below the first remainder
  localparam int unsigned StepW    = 5;   // counts the ThetaW divide steps

  localparam logic [CountW-1:0] MaxSamples     = 9'd256;
  localparam logic [CountW-1:0] SampleSizeRst  = 9'd2;
  localparam logic [LenW-1:0]   LocusLengthRst = 32'd1;

  // Configuration register indexes.
  localparam logic RegSampleSize  = 1'b0;
  localparam logic RegLocusLength = 1'b1;

  typedef logic [CountW-1:0] count_t;
  typedef logic [SumW-1:0]   sum_t;
  typedef logic [DenW-1:0]   den_t;
  typedef logic [ThetaW-1:0] theta_t;

  // Sample size as used by the arithmetic: clamped to the limit, zero as one.
  function automatic count_t eff_n(input count_t n);
    count_t r;
    r = n;
    if (r > MaxSamples) begin
      r = MaxSamples;
    end
    if (r == '0) begin
      r = count_t'(1);
    end
    return r;
  endfunction

endpackage

// File: sv/nda_in_if.sv
// ----------------------------------------------------------------------------
// nda_in_if: per-site input channel
// Carries one derived-allele count and the last-site mark with valid/ready.
// ----------------------------------------------------------------------------
interface nda_in_if;
  logic                        valid;
  logic                        ready;
  logic [nda_pkg::CountW-1:0]  derived_count;
  logic                        last_site;

  modport source (output valid, output derived_count, output last_site, input ready);
  modport sink   (input valid, input derived_count, input last_site, output ready);
endinterface

// File: sv/nda_out_if.sv
// ----------------------------------------------------------------------------
// nda_out_if: per-locus result channel
// Carries theta per site in Q8.24 and the saturation flag with valid/ready.
// ----------------------------------------------------------------------------
interface nda_out_if;
  logic                        valid;
  logic                        ready;
  logic [nda_pkg::ThetaW-1:0]  theta_per_site;
  logic                        saturated;

  modport source (output valid, output theta_per_site, output saturated, input ready);
  modport sink   (input valid, input theta_per_site, input saturated, output ready);
endinterface

// File: sv/nucleotide_diversity_accumulator.sv
// ----------------------------------------------------------------------------
// nucleotide_diversity_accumulator: nucleotide diversity per site
// Accumulates d*(n-d) per site and divides by n*n*L at the end of a locus.
// ----------------------------------------------------------------------------
// A site that is not marked last is taken while the block is idle, so such
// sites can stream at one per clock. A site marked last closes the locus:
// its term is added, then n*n and n*n*L are formed in the StNsq and StDen
// states, StChk checks for saturation, and a restoring divider built on a
// single 50-bit subtractor produces the 32 quotient bits one per cycle
// before StOut loads the result register. The input is not ready from a
// last site until that load (the divide is skipped on saturation), which
// waits while the previous result still sits unread in the output register.
// Theta is floor(2*sum*2^24/(n*n*L)), clamped to all ones with saturated set.
module nucleotide_diversity_accumulator (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic                          cfg_index,
  input  logic [nda_pkg::CfgDataW-1:0]  cfg_wdata,
  nda_in_if.sink                        in_if,
  nda_out_if.source                     out_if
);

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StNsq  = 3'd1;
  localparam logic [2:0] StDen  = 3'd2;
  localparam logic [2:0] StChk  = 3'd3;
  localparam logic [2:0] StDiv  = 3'd4;
  localparam logic [2:0] StOut  = 3'd5;

  logic [2:0]                      state_r;
  nda_pkg::count_t                 sample_size_r;
  logic [nda_pkg::LenW-1:0]        locus_length_r;
  nda_pkg::sum_t                   sum_r;
  nda_pkg::sum_t                   sum_nxt;
  nda_pkg::sum_t                   num_r;
  logic [nda_pkg::NsqW-1:0]        nsq_r;
  nda_pkg::den_t                   den_r;
  nda_pkg::den_t                   rem_r;
  logic [nda_pkg::LoBits-1:0]      lo_r;
  nda_pkg::theta_t                 quo_r;
  logic                            sat_r;
  logic [nda_pkg::StepW-1:0]       step_r;
  logic                            out_valid_r;
  nda_pkg::theta_t                 out_theta_r;
  logic                            out_sat_r;

  nda_pkg::count_t                 n_eff;
  nda_pkg::count_t                 d_clamp;
  logic [2*nda_pkg::CountW-1:0]    term;
  logic [nda_pkg::SumW:0]          sum_add;
  logic [2*nda_pkg::CountW-1:0]    nsq_full;
  logic [nda_pkg::LenW-1:0]        len_eff;
  logic [nda_pkg::DenW:0]          sub_a;
  logic [nda_pkg::DenW+1:0]        sub_diff;
  logic                            sub_geq;
  logic                            in_fire;
  logic                            out_free;
  logic                            out_load;

  assign n_eff    = nda_pkg::eff_n(sample_size_r);
  assign d_clamp  = (in_if.derived_count > n_eff) ? n_eff : in_if.derived_count;
  assign term     = (2*nda_pkg::CountW)'(d_clamp) * (2*nda_pkg::CountW)'(n_eff - d_clamp);
  assign sum_add  = {1'b0, sum_r} + (nda_pkg::SumW+1)'(term);
  assign sum_nxt  = sum_add[nda_pkg::SumW] ? '1 : sum_add[nda_pkg::SumW-1:0];
  assign nsq_full = (2*nda_pkg::CountW)'(n_eff) * (2*nda_pkg::CountW)'(n_eff);
  assign len_eff  = (locus_length_r == '0) ? nda_pkg::LenW'(1) : locus_length_r;

  // The one subtractor: the saturation check compares sum/128 against the
  // divisor, and each divide step compares the shifted remainder.
  always_comb begin
    if (state_r == StChk) begin
      sub_a = (nda_pkg::DenW+1)'(num_r[nda_pkg::SumW-1:nda_pkg::LoBits]);
    end else begin
      sub_a = {rem_r, lo_r[nda_pkg::LoBits-1]};
    end
  end
  assign sub_diff = {1'b0, sub_a} - {2'b00, den_r};
  assign sub_geq  = ~sub_diff[nda_pkg::DenW+1];

  assign in_if.ready = (state_r == StIdle);
  assign in_fire     = in_if.valid && (state_r == StIdle);
  assign out_free    = !out_valid_r || out_if.ready;
  assign out_load    = (state_r == StOut) && out_free;

  assign out_if.valid          = out_valid_r;
  assign out_if.theta_per_site = out_theta_r;
  assign out_if.saturated      = out_sat_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= StIdle;
      sample_size_r  <= nda_pkg::SampleSizeRst;
      locus_length_r <= nda_pkg::LocusLengthRst;
      sum_r          <= '0;
      out_valid_r    <= 1'b0;
      step_r         <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          nda_pkg::RegSampleSize:  sample_size_r  <= cfg_wdata[nda_pkg::CountW-1:0];
          nda_pkg::RegLocusLength: locus_length_r <= cfg_wdata[nda_pkg::LenW-1:0];
          default: ;
        endcase
      end

      if (out_load) begin
        out_valid_r <= 1'b1;
        out_theta_r <= quo_r;
        out_sat_r   <= sat_r;
      end else if (out_if.ready) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        StIdle: begin
          if (in_fire) begin
            if (in_if.last_site) begin
              // Hand the closed sum to the divider and start the next locus.
              num_r   <= sum_nxt;
              sum_r   <= '0;
              state_r <= StNsq;
            end else begin
              sum_r <= sum_nxt;
            end
          end
        end
        StNsq: begin
          nsq_r   <= nsq_full[nda_pkg::NsqW-1:0];
          state_r <= StDen;
        end
        StDen: begin
          den_r   <= nda_pkg::DenW'(nsq_r) * nda_pkg::DenW'(len_eff);
          state_r <= StChk;
        end
        StChk: begin
          if (sub_geq) begin
            quo_r   <= '1;
            sat_r   <= 1'b1;
            state_r <= StOut;
          end else begin
            rem_r   <= nda_pkg::DenW'(num_r[nda_pkg::SumW-1:nda_pkg::LoBits]);
            lo_r    <= num_r[nda_pkg::LoBits-1:0];
            quo_r   <= '0;
            sat_r   <= 1'b0;
            step_r  <= '0;
            state_r <= StDiv;
          end
        end
        StDiv: begin
          rem_r  <= sub_geq ? sub_diff[nda_pkg::DenW-1:0] : sub_a[nda_pkg::DenW-1:0];
          quo_r  <= {quo_r[nda_pkg::ThetaW-2:0], sub_geq};
          lo_r   <= {lo_r[nda_pkg::LoBits-2:0], 1'b0};
          step_r <= step_r + 1'b1;
          if (step_r == '1) begin
            state_r <= StOut;
          end
        end
        StOut: begin
          if (out_free) begin
            state_r <= StIdle;
          end
        end
        default: begin
          state_r <= StIdle;
        end
      endcase
    end
  end

endmodule

// File: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: testbench for nucleotide_diversity_accumulator
// Streams per-site derived-allele counts through the input channel and
// predicts theta per site for every locus closed by a last site. Each result
// from the output channel is compared field by field with the oldest
// prediction. A directed opening covers field extremes, clamping, zero
// registers and register changes in the middle of a locus. The random phases
// that follow vary the registers and the idling on both channels.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CycleLimit  = 400000;
  localparam int unsigned DrainCycles = 48;   // a little over the time of one divide
  localparam int unsigned PhaseSites  = 100;
  localparam int unsigned NumPhases   = 16;

  // Predicts theta per site for each locus and holds the results not yet seen.
  class theta_scoreboard;
    typedef struct packed {
      nda_pkg::theta_t theta;
      logic            saturated;
    } locus_result_t;

    localparam nda_pkg::sum_t SumMax = {nda_pkg::SumW{1'b1}};

    nda_pkg::count_t          samples_reg;
    logic [nda_pkg::LenW-1:0] length_reg;
    nda_pkg::sum_t            het_sum;
    locus_result_t            theta_q[$];
    int unsigned              sites_taken;
    int unsigned              results_checked;
    int unsigned              saturated_seen;
    int unsigned              mismatches;

    function new();
      samples_reg     = nda_pkg::SampleSizeRst;
      length_reg      = nda_pkg::LocusLengthRst;
      het_sum         = '0;
      sites_taken     = 0;
      results_checked = 0;
      saturated_seen  = 0;
      mismatches      = 0;
    endfunction

    function void write_reg(logic idx, logic [nda_pkg::CfgDataW-1:0] val);
      if (idx == nda_pkg::RegSampleSize) begin
        samples_reg = val[nda_pkg::CountW-1:0];
      end else begin
        length_reg = val[nda_pkg::LenW-1:0];
      end
    endfunction

    // Sample size as the arithmetic sees it.
    function nda_pkg::count_t active_n();
      nda_pkg::count_t n;
      n = samples_reg;
      if (n > nda_pkg::MaxSamples) begin
        n = nda_pkg::MaxSamples;
      end
      if (n == '0) begin
        n = nda_pkg::count_t'(1);
      end
      return n;
    endfunction

    function int unsigned pending();
      return theta_q.size();
    endfunction

    function void note_site(nda_pkg::count_t count_in, logic last);
      nda_pkg::count_t          n;
      nda_pkg::count_t          d;
      nda_pkg::sum_t            term;
      logic [nda_pkg::LenW-1:0] len;
      nda_pkg::den_t            den;
      logic [95:0]              quot;
      locus_result_t            res;
      n = active_n();
      d = (count_in > n) ? n : count_in;
      term = nda_pkg::sum_t'(d) * nda_pkg::sum_t'(n - d);
      if (term > SumMax - het_sum) begin
        het_sum = SumMax;
      end else begin
        het_sum = het_sum + term;
      end
      sites_taken++;
      if (last) begin
        len = (length_reg == '0) ? nda_pkg::LenW'(1) : length_reg;
        den = nda_pkg::den_t'(n) * nda_pkg::den_t'(n) * nda_pkg::den_t'(len);
        // 2*sum*2^24 is the sum shifted by 25; wide enough that nothing drops.
        quot = (96'(het_sum) << 25) / 96'(den);
        res.saturated = (quot > 96'hFFFF_FFFF);
        res.theta = res.saturated ? '1 : quot[nda_pkg::ThetaW-1:0];
        theta_q.push_back(res);
        het_sum = '0;
      end
    endfunction

    function void check_result(nda_pkg::theta_t theta, logic sat);
      locus_result_t want;
      results_checked++;
      if (sat) begin
        saturated_seen++;
      end
      if (theta_q.size() == 0) begin
        mismatches++;
        $display("%0t: result with nothing expected: theta_per_site=%h saturated=%b",
                 $time, theta, sat);
        return;
      end
      want = theta_q.pop_front();
      if (theta !== want.theta) begin
        mismatches++;
        $display("%0t: theta_per_site mismatch: expected %h, actual %h",
                 $time, want.theta, theta);
      end
      if (sat !== want.saturated) begin
        mismatches++;
        $display("%0t: saturated mismatch: expected %b, actual %b",
                 $time, want.saturated, sat);
      end
    endfunction
  endclass

  logic                         clk;
  logic                         rst_n;
  logic                         cfg_we;
  logic                         cfg_index;
  logic [nda_pkg::CfgDataW-1:0] cfg_wdata;

  nda_in_if  in_ch();
  nda_out_if out_ch();

  theta_scoreboard sb = new();

  int unsigned in_idle_pct;
  int unsigned out_stall_pct;
  int unsigned cycle_count;

  nucleotide_diversity_accumulator DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .in_if    (in_ch),
    .out_if   (out_ch)
  );

  initial begin
    clk = 1'b0;
    forever begin
      #2 clk = ~clk;
    end
  end

  // Offers one site and returns once it has been transferred.
  task automatic send_site(nda_pkg::count_t d, logic last);
    while ($urandom_range(99) < in_idle_pct) begin
      @(negedge clk);
      in_ch.valid <= 1'b0;
    end
    @(negedge clk);
    in_ch.valid         <= 1'b1;
    in_ch.derived_count <= d;
    in_ch.last_site     <= last;
    do begin
      @(posedge clk);
    end while (!in_ch.ready);
    sb.note_site(d, last);
  endtask

  task automatic stop_sending();
    @(negedge clk);
    in_ch.valid <= 1'b0;
  endtask

  task automatic wait_results();
    while (sb.pending() != 0) begin
      @(posedge clk);
    end
  endtask

  // Brings the block to rest so that a register may change.
  task automatic settle();
    stop_sending();
    wait_results();
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic program_reg(logic idx, logic [nda_pkg::CfgDataW-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    sb.write_reg(idx, val);
  endtask

  // Result side: ready is drawn at each falling edge.
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      out_ch.ready <= ($urandom_range(99) >= out_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      sb.check_result(out_ch.theta_per_site, out_ch.saturated);
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("%0t: no progress after %0d cycles", $time, CycleLimit);
      $display("nucleotide_diversity_accumulator test failed");
      $finish;
    end
  end

  initial begin
    int unsigned     phase;
    int unsigned     taken;
    int unsigned     run_len;
    int unsigned     locus_pos;
    nda_pkg::count_t n;
    nda_pkg::count_t d;
    logic            last;

    cycle_count         = 0;
    in_idle_pct         = 0;
    out_stall_pct       = 0;
    rst_n               = 1'b0;
    cfg_we              = 1'b0;
    cfg_index           = nda_pkg::RegSampleSize;
    cfg_wdata           = '0;
    in_ch.valid         = 1'b0;
    in_ch.derived_count = '0;
    in_ch.last_site     = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Registers straight out of reset.
    send_site(9'd1, 1'b1);

    // Full sample size with a zero locus length; counts at and above n.
    settle();
    program_reg(nda_pkg::RegSampleSize, 32'd256);
    program_reg(nda_pkg::RegLocusLength, 32'd0);
    send_site(9'd0, 1'b0);
    send_site(9'd256, 1'b0);
    send_site(9'd511, 1'b0);
    send_site(9'd128, 1'b0);
    send_site(9'd255, 1'b1);

    // A large sum divided by n = 1 overflows the integer part at once.
    send_site(9'd128, 1'b0);
    settle();
    program_reg(nda_pkg::RegSampleSize, 32'd1);
    send_site(9'd0, 1'b1);

    // A sum of 128 over a unit denominator is the smallest that saturates;
    // the closing site uses a zero sample size.
    settle();
    program_reg(nda_pkg::RegSampleSize, 32'd16);
    program_reg(nda_pkg::RegLocusLength, 32'd1);
    send_site(9'd8, 1'b0);
    send_site(9'd8, 1'b0);
    settle();
    program_reg(nda_pkg::RegSampleSize, 32'd0);
    send_site(9'd5, 1'b1);

    // A sum of 127 is the largest that stays short of saturation.
    settle();
    program_reg(nda_pkg::RegSampleSize, 32'd128);
    send_site(9'd1, 1'b0);
    settle();
    program_reg(nda_pkg::RegSampleSize, 32'd1);
    send_site(9'd1, 1'b1);

    // Sample sizes above the limit, and the longest locus.
    settle();
    program_reg(nda_pkg::RegSampleSize, 32'd511);
    program_reg(nda_pkg::RegLocusLength, 32'hFFFF_FFFF);
    send_site(9'd100, 1'b0);
    send_site(9'd300, 1'b1);
    settle();
    program_reg(nda_pkg::RegSampleSize, 32'd257);
    program_reg(nda_pkg::RegLocusLength, 32'd2);
    send_site(9'd128, 1'b1);

    settle();
    program_reg(nda_pkg::RegSampleSize, 32'd3);
    program_reg(nda_pkg::RegLocusLength, 32'd7);
    send_site(9'd0, 1'b0);
    send_site(9'd1, 1'b0);
    send_site(9'd2, 1'b0);
    send_site(9'd3, 1'b0);
    send_site(9'd4, 1'b1);
    send_site(9'd0, 1'b1);

    // Random phases. A phase may end in the middle of a locus, so register
    // changes also land between the sites of one locus.
    for (phase = 0; phase < NumPhases; phase++) begin
      settle();
      case (phase % 4)
        0: begin
          in_idle_pct   = 0;
          out_stall_pct = 0;
        end
        1: begin
          in_idle_pct   = 67;
          out_stall_pct = 0;
        end
        2: begin
          in_idle_pct   = 0;
          out_stall_pct = 67;
        end
        default: begin
          in_idle_pct   = 12;
          out_stall_pct = 12;
        end
      endcase
      if ($urandom_range(3) != 0) begin
        case ($urandom_range(9))
          0: program_reg(nda_pkg::RegSampleSize, 32'd0);
          1: program_reg(nda_pkg::RegSampleSize, 32'd1);
          2: program_reg(nda_pkg::RegSampleSize, 32'd2);
          3: program_reg(nda_pkg::RegSampleSize, 32'd256);
          4: program_reg(nda_pkg::RegSampleSize, 32'd257);
          5: program_reg(nda_pkg::RegSampleSize, 32'd511);
          default: program_reg(nda_pkg::RegSampleSize, $urandom_range(255, 3));
        endcase
      end
      if ($urandom_range(3) != 0) begin
        case ($urandom_range(8))
          0: program_reg(nda_pkg::RegLocusLength, 32'd0);
          1: program_reg(nda_pkg::RegLocusLength, 32'd1);
          2: program_reg(nda_pkg::RegLocusLength, 32'd2);
          3: program_reg(nda_pkg::RegLocusLength, 32'hFFFF_FFFF);
          4: program_reg(nda_pkg::RegLocusLength, $urandom);
          5: program_reg(nda_pkg::RegLocusLength, $urandom_range(4096, 1));
          default: program_reg(nda_pkg::RegLocusLength, $urandom_range(64, 1));
        endcase
      end
      taken = 0;
      while (taken < PhaseSites) begin
        run_len = ($urandom_range(7) == 0) ? $urandom_range(60, 20) : $urandom_range(12, 1);
        for (locus_pos = 1; locus_pos <= run_len && taken < PhaseSites; locus_pos++) begin
          n = sb.active_n();
          case ($urandom_range(9))
            0: d = nda_pkg::count_t'($urandom_range(511, 0));
            1: d = n + nda_pkg::count_t'($urandom_range(3, 1));
            2: d = '0;
            3: d = n;
            default: d = nda_pkg::count_t'($urandom_range(n, 0));
          endcase
          last = (locus_pos == run_len);
          send_site(d, last);
          taken++;
          // Now and then hold the sender until every result is back.
          if (last && $urandom_range(9) == 0) begin
            stop_sending();
            wait_results();
          end
        end
      end
    end

    stop_sending();
    wait_results();
    repeat (DrainCycles) @(posedge clk);

    $display("Streamed %0d sites over %0d register phases; %0d locus results checked.",
             sb.sites_taken, NumPhases + 1, sb.results_checked);
    $display("%0d of those results saturated; %0d field mismatches.",
             sb.saturated_seen, sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("nucleotide_diversity_accumulator test passed");
    end else begin
      $display("nucleotide_diversity_accumulator test failed");
    end
    $finish;
  end

endmodule

// File: nucleotide_diversity_accumulator.f
sv/nda_pkg.sv
sv/nda_in_if.sv
sv/nda_out_if.sv
sv/nucleotide_diversity_accumulator.sv
tb/tb_top.sv
